[rtl/lru_block_location_cache_unit_defines.svh]
// Assertion macros shared by the block location cache RTL.
`ifndef LRU_BLOCK_LOCATION_CACHE_UNIT_DEFINES_SVH
`define LRU_BLOCK_LOCATION_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRUBLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRUBLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lrublc_pkg.sv]
// Shared types and constants for the block location cache.
package lrublc_pkg;

   localparam int LRUBLC_CACHE_ENTRIES = 8;
   localparam int LRUBLC_KEY_W         = 14;
   localparam int LRUBLC_LOC_W         = 22;

   // Command codes
   localparam logic LRUBLC_CMD_LOOKUP = 1'b0;
   localparam logic LRUBLC_CMD_INSERT = 1'b1;

   typedef struct packed {
      logic                    command;
      logic [LRUBLC_KEY_W-1:0] block_number;
      logic [LRUBLC_LOC_W-1:0] location;
      logic                    location_present;
   } lrublc_req_type;

   typedef struct packed {
      logic                    hit;
      logic [LRUBLC_LOC_W-1:0] found_location;
      logic                    found_present;
   } lrublc_rsp_type;

   // Stored contents of one table slot
   typedef struct packed {
      logic [LRUBLC_KEY_W-1:0] key;
      logic [LRUBLC_LOC_W-1:0] location;
      logic                    present;
   } lrublc_data_type;

   typedef struct packed {
      logic            valid;
      lrublc_data_type data;
   } lrublc_entry_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                    exec;
      logic                    hit_any;
      logic                    insert;
      logic [LRUBLC_KEY_W-1:0] key;
   } lrublc_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } lrublc_state_type;

endpackage

[rtl/lrublc_cell.sv]
// One slot of the most-recently-used chain: compare, forward match, shift in.
module lrublc_cell
   import lrublc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  lrublc_ctl_type   ctl,
   input  lrublc_entry_type prev_entry,
   output lrublc_entry_type entry,
   input  logic             match_tail_in,
   output logic             match_tail_out,
   input  lrublc_data_type  found_in,
   output lrublc_data_type  found_out,
   output logic             match
);

   logic            valid_ff;
   logic            valid_in;
   lrublc_data_type data_ff;
   lrublc_data_type data_in;
   logic            shift;

   // Compare own key against the request key
   assign match = valid_ff && (data_ff.key == ctl.key);

   // Tell the front whether this slot or any slot behind it matched
   assign match_tail_out = match | match_tail_in;

   // Pass the matching slot's contents toward the front
   assign found_out = match ? data_ff : found_in;

   // Take the neighbor's entry when the hit lies here or behind, or on insert miss
   assign shift = ctl.exec && (ctl.hit_any ? match_tail_out : ctl.insert);

   assign valid_in = shift ? prev_entry.valid : valid_ff;
   assign data_in  = shift ? prev_entry.data  : data_ff;

   assign entry.valid = valid_ff;
   assign entry.data  = data_ff;

   // Hold or advance the slot valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold or advance the slot contents
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[rtl/lru_block_location_cache_unit.sv]
// Top level of the block location cache: request register, sequencer, cell chain.
// Fully associative block-number-to-flash-location cache of CACHE_ENTRIES slots kept in
// most-recently-used order by a chain of cells. The request word is registered at the
// start edge, then while busy every cell compares its key and the chain shifts by one
// slot up to the hit (or over the whole chain on an insert miss). The result word is
// shown on rsp_word with rsp_strobe for exactly one cycle, starting the cycle after busy,
// and a new start is taken in that same cycle; no start is taken while busy. The receiver
// must take each strobed word as it comes. On a miss found_location and found_present
// read zero; an insert of a block already held keeps its old location and reports it as
// a hit. After reset all slots are invalid.
module lru_block_location_cache_unit
   import lrublc_pkg::*;
#(
   parameter int CACHE_ENTRIES = LRUBLC_CACHE_ENTRIES
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  lrublc_req_type req_word,
   output logic           rsp_strobe,
   output lrublc_rsp_type rsp_word
);

`include "lru_block_location_cache_unit_defines.svh"

   lrublc_state_type state_ff;
   lrublc_state_type state_in;
   lrublc_req_type   req_ff;
   lrublc_req_type   req_in;
   logic             rsp_strobe_ff;
   logic             rsp_strobe_in;
   lrublc_rsp_type   rsp_word_ff;
   lrublc_rsp_type   rsp_word_in;

   logic             accept;
   logic             exec;
   lrublc_ctl_type   ctl;
   lrublc_entry_type front_entry;
   lrublc_data_type  new_data;

   lrublc_entry_type entry_vec [CACHE_ENTRIES];
   lrublc_data_type  found_vec [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] tail_vec;
   logic [CACHE_ENTRIES-1:0] match_vec;
   logic [CACHE_ENTRIES-1:0] valid_vec;

   assign accept = start && (state_ff == ST_IDLE);
   assign exec   = (state_ff == ST_EXEC);
   assign busy   = exec;

   // Sequence: idle until start, then execute, then back to idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request word
   assign req_in = accept ? req_word : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Broadcast control to the chain
   assign ctl.exec    = exec;
   assign ctl.hit_any = tail_vec[0];
   assign ctl.insert  = (req_ff.command == LRUBLC_CMD_INSERT);
   assign ctl.key     = req_ff.block_number;

   // Front of the chain: the hit entry, or the new entry on an insert miss
   assign new_data.key      = req_ff.block_number;
   assign new_data.location = req_ff.location;
   assign new_data.present  = req_ff.location_present;

   assign front_entry.valid = 1'b1;
   assign front_entry.data  = tail_vec[0] ? found_vec[0] : new_data;

   // Chain of cells, slot 0 most recent
   for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
      lrublc_entry_type prev_entry;
      logic             tail_in;
      lrublc_data_type  found_in;

      if (i == 0) begin : g_head
         assign prev_entry = front_entry;
      end else begin : g_body
         assign prev_entry = entry_vec[i-1];
      end

      if (i == CACHE_ENTRIES - 1) begin : g_last
         assign tail_in  = 1'b0;
         assign found_in = '0;
      end else begin : g_inner
         assign tail_in  = tail_vec[i+1];
         assign found_in = found_vec[i+1];
      end

      lrublc_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl),
         .prev_entry     (prev_entry),
         .entry          (entry_vec[i]),
         .match_tail_in  (tail_in),
         .match_tail_out (tail_vec[i]),
         .found_in       (found_in),
         .found_out      (found_vec[i]),
         .match          (match_vec[i])
      );

      assign valid_vec[i] = entry_vec[i].valid;
   end

   // Register the result word at the end of the execute cycle
   assign rsp_strobe_in              = exec;
   assign rsp_word_in.hit            = tail_vec[0];
   assign rsp_word_in.found_location = tail_vec[0] ? found_vec[0].location : '0;
   assign rsp_word_in.found_present  = tail_vec[0] && found_vec[0].present;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Checks on sequencing, result shape and table order
   `LRUBLC_ASSERT_NEXT(a_accept_exec, clock, reset, accept, busy && !rsp_strobe,
      "accepted request did not enter execute")
   `LRUBLC_ASSERT_NEXT(a_exec_strobe, clock, reset, exec, rsp_strobe && !busy,
      "execute cycle did not produce a result strobe")
   `LRUBLC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_strobe && !rsp_word.hit,
      (rsp_word.found_location == '0) && !rsp_word.found_present,
      "miss result carries a nonzero location")
   `LRUBLC_ASSERT_NOW(a_single_match, clock, reset, exec, $onehot0(match_vec),
      "more than one slot matched the key")
   `LRUBLC_ASSERT_NOW(a_valid_prefix, clock, reset, 1'b1,
      (valid_vec & (valid_vec + 1'b1)) == '0,
      "valid slots do not form a prefix of the chain")

endmodule

[verif/testbench.sv]
// Testbench for the block location cache: random and directed lookups and inserts, scoreboard check.
module testbench;
   import lrublc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = LRUBLC_CACHE_ENTRIES;
   localparam int RANDOM_WORDS = 900;
   localparam int KEY_POOL     = 12;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   // LRU table predictor with the queue of replies it owes
   class location_cache_scoreboard;
      lrublc_entry_type slots [SLOTS];
      lrublc_rsp_type   expected_replies [$];
      int unsigned      failures;

      function new();
         foreach (slots[i]) slots[i] = '0;
         failures = 0;
      endfunction

      // Predict the reply to an accepted request word and update the table
      function void note_request(lrublc_req_type req);
         int               idx;
         int               hit_slot;
         lrublc_entry_type moved;
         lrublc_rsp_type   reply;
         hit_slot = -1;
         reply    = '0;
         moved    = '0;
         for (idx = 0; idx < SLOTS; idx++) begin
            if (hit_slot < 0 && slots[idx].valid && slots[idx].data.key == req.block_number)
               hit_slot = idx;
         end
         if (hit_slot >= 0) begin
            moved                = slots[hit_slot];
            reply.hit            = 1'b1;
            reply.found_location = moved.data.location;
            reply.found_present  = moved.data.present;
         end else if (req.command == LRUBLC_CMD_INSERT) begin
            // Overwrite the least recently used slot
            hit_slot              = SLOTS - 1;
            moved.valid           = 1'b1;
            moved.data.key        = req.block_number;
            moved.data.location   = req.location;
            moved.data.present    = req.location_present;
         end
         // Move the touched slot to the front
         if (hit_slot >= 0) begin
            for (idx = hit_slot; idx > 0; idx--) slots[idx] = slots[idx - 1];
            slots[0] = moved;
         end
         expected_replies.push_back(reply);
      endfunction

      // Compare a strobed reply word with the oldest prediction
      function void check_response(lrublc_rsp_type got);
         lrublc_rsp_type want;
         if (expected_replies.size() == 0) begin
            $error("rsp_word strobed with no request outstanding");
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            failures++;
         end
         if (got.found_location !== want.found_location) begin
            $error("found_location: expected 0x%06h, actual 0x%06h",
                   want.found_location, got.found_location);
            failures++;
         end
         if (got.found_present !== want.found_present) begin
            $error("found_present: expected %0d, actual %0d",
                   want.found_present, got.found_present);
            failures++;
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset;
   logic           start;
   logic           busy;
   lrublc_req_type req_word;
   logic           rsp_strobe;
   lrublc_rsp_type rsp_word;

   location_cache_scoreboard lru_board = new();
   int                       stall_cycles = 0;
   bit                       no_idle = 1'b0;
   logic [LRUBLC_KEY_W-1:0]  key_pool [KEY_POOL];

   lru_block_location_cache_unit #(
      .CACHE_ENTRIES(SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check replies, note accepted requests, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) lru_board.check_response(rsp_word);
         if (start && !busy) lru_board.note_request(req_word);
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Send one request word after a random pause, hold it until taken
   task automatic issue(input logic cmd, input logic [LRUBLC_KEY_W-1:0] key,
                        input logic [LRUBLC_LOC_W-1:0] loc, input logic present);
      lrublc_req_type word;
      int             gap;
      word.command          = cmd;
      word.block_number     = key;
      word.location         = loc;
      word.location_present = present;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= word;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int n;
      int k;
      logic [LRUBLC_KEY_W-1:0] key;

      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: lookups miss and ignore the location fields
      issue(LRUBLC_CMD_LOOKUP, '0, '1, 1'b1);
      issue(LRUBLC_CMD_LOOKUP, '1, '1, 1'b1);
      // Extreme keys and locations, one cached as absent
      issue(LRUBLC_CMD_INSERT, '0, '0, 1'b0);
      issue(LRUBLC_CMD_INSERT, '1, '1, 1'b1);
      issue(LRUBLC_CMD_LOOKUP, '0, '1, 1'b1);
      issue(LRUBLC_CMD_LOOKUP, '1, '0, 1'b0);
      // Insert of a held key keeps the old location
      issue(LRUBLC_CMD_INSERT, '1, '0, 1'b0);
      // Fill the remaining slots, then evict the least recent one
      for (k = 1; k <= SLOTS - 2; k++)
         issue(LRUBLC_CMD_INSERT, LRUBLC_KEY_W'(k), LRUBLC_LOC_W'($urandom()), k[0]);
      issue(LRUBLC_CMD_INSERT, LRUBLC_KEY_W'(SLOTS - 1), LRUBLC_LOC_W'($urandom()), 1'b1);
      issue(LRUBLC_CMD_LOOKUP, '0, '0, 1'b0);
      // Hit in the last slot twice, then insert a held key
      issue(LRUBLC_CMD_LOOKUP, '1, '0, 1'b0);
      issue(LRUBLC_CMD_LOOKUP, LRUBLC_KEY_W'(1), '0, 1'b0);
      issue(LRUBLC_CMD_INSERT, LRUBLC_KEY_W'(SLOTS - 1), '1, 1'b0);

      // Random traffic over a small working set so hits and evictions both occur
      foreach (key_pool[i]) key_pool[i] = LRUBLC_KEY_W'($urandom());
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n % 100 == 99)
            key_pool[$urandom_range(0, KEY_POOL - 1)] = LRUBLC_KEY_W'($urandom());
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
         else
            key = LRUBLC_KEY_W'($urandom());
         issue($urandom_range(0, 1) ? LRUBLC_CMD_INSERT : LRUBLC_CMD_LOOKUP,
               key, LRUBLC_LOC_W'($urandom()), 1'($urandom_range(0, 1)));
      end
      start <= 1'b0;

      // Drain outstanding replies, then let the block settle
      while (lru_board.expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (lru_board.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/lrublc_pkg.sv
rtl/lrublc_cell.sv
rtl/lru_block_location_cache_unit.sv
verif/testbench.sv
